[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file ktns_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/ktns_pkg.sv]
// ----------------------------------------------------------------------------
// ktns_pkg
// Shared types and constants of the tool switch counter.
// ----------------------------------------------------------------------------
package ktns_pkg;
  localparam int MaxJobs  = 64;
  localparam int MaxTools = 64;
  localparam int JobW     = $clog2(MaxJobs);
  localparam int JcntW    = $clog2(MaxJobs + 1);
  localparam int ToolW    = 6;
  localparam int SlotW    = 6;
  localparam int CountW   = 13;
  localparam logic [CountW-1:0] SwitchLimit = 13'h1FFF;
  localparam logic [6:0] EmptySlot = 7'd127;
  localparam logic [1:0] RegCap   = 2'd0;
  localparam logic [1:0] RegTools = 2'd1;

  typedef enum logic [3:0] {
    ST_LOAD,   // take rows
    ST_NU,     // next use per tool, scan rows
    ST_THR,    // threshold from next-use counts
    ST_FILL1,  // place tools below threshold
    ST_FILL2,  // place tools at threshold
    ST_JOB,    // pick next required tool
    ST_HIT,    // search slots for tool
    ST_EVW,    // weigh slots
    ST_WSCAN,  // scan rows for slot weight
    ST_DONE    // hold result
  } state_t;
endpackage

[hw/rtl/ktns_row_mem.sv]
// ----------------------------------------------------------------------------
// ktns_row_mem
// Job row store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ktns_row_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ktns_pkg::JobW-1:0]  waddr,
  input  logic [63:0]                wdata,
  input  logic [ktns_pkg::JobW-1:0]  raddr,
  output logic [63:0]                rdata
);
  logic [63:0] mem [ktns_pkg::MaxJobs];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/tool_switch_count_ktns.sv]
// ----------------------------------------------------------------------------
// tool_switch_count_ktns
// Tool switch counter with the keep-tool-needed-soonest policy.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in_     | slave     | tdata = tool_mask[63:0]; tuser = last_job; one job row
// out_    | master    | tdata = switch_count, job_total, overflow (24 bits)
// cfg_    | APB       | reg 0 magazine_capacity, reg 1 tools_in_use
//
// Rows are taken one per cycle with no gap. The last row starts the evaluation
// burst; one shared row-memory read port and one compare unit do the work, and
// every row, next-use or slot read is registered. Next use and threshold sweep
// the tools against the rows; each eviction weighs every slot with a scan of
// the rows from the current job on. The block is not ready from the last row
// until the result transaction is taken. Reset is synchronous, active low; no
// store needs clearing, a fill count marks the empty slots. A stall on out_
// holds the result.
// ----------------------------------------------------------------------------
module tool_switch_count_ktns (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] tool_mask
  input  logic        in_tuser,   // [0] last_job
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [12:0] switch_count, [19:13] job_total,
                                  // [20] overflow, [23:21] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int JW = ktns_pkg::JobW;
  localparam int NW = ktns_pkg::JcntW;

  ktns_pkg::state_t state_r, state_nxt;

  logic [6:0] cap_reg_r, tools_reg_r;
  logic [NW-1:0] row_cnt_r, row_cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [12:0] sw_r, sw_nxt;
  logic [6:0] slot_mem [64];
  logic [6:0] slot_rd;
  logic [NW-1:0] nu_mem [64];
  logic [NW-1:0] nu_rd;

  // loop counters
  logic [6:0] t_r, t_nxt;          // tool index (0..64)
  logic [NW-1:0] j_r, j_nxt;       // row index
  logic [NW-1:0] i_r, i_nxt;       // current job in eviction pass
  logic [6:0] s_r, s_nxt;          // slot index
  logic [6:0] q_r, q_nxt;          // fill count: slots at or above it are empty
  logic [NW-1:0] thr_r, thr_nxt;
  logic [6:0] soma_r, soma_nxt;
  logic [6:0] best_r, best_nxt;
  logic [NW-1:0] bw_r, bw_nxt;
  logic rd_pend_r, rd_pend_nxt;    // memory read in flight

  // effective configuration
  logic [6:0] cols, cap;
  assign cols = (tools_reg_r > 7'd64) ? 7'd64 : tools_reg_r;
  assign cap  = (cap_reg_r == 7'd0) ? 7'd1 : ((cap_reg_r > 7'd64) ? 7'd64 : cap_reg_r);

  // row store
  logic mem_we;
  logic [JW-1:0] mem_raddr;
  logic [63:0] mem_rdata;
  assign in_tready = (state_r == ktns_pkg::ST_LOAD);
  assign mem_we = in_tvalid && in_tready && (row_cnt_r < NW'(ktns_pkg::MaxJobs));

  ktns_row_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(row_cnt_r[JW-1:0]), .wdata(in_tdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_reg_r   <= 7'd16;
      tools_reg_r <= 7'd64;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == ktns_pkg::RegCap[0]) cap_reg_r <= cfg_pwdata[6:0];
      else if (cfg_paddr[2] == ktns_pkg::RegTools[0]) tools_reg_r <= cfg_pwdata[6:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ktns_pkg::RegCap[0]) cfg_prdata[6:0] = cap_reg_r;
    else if (cfg_paddr[2] == ktns_pkg::RegTools[0]) cfg_prdata[6:0] = tools_reg_r;
  end

  // shared compare: bit of the read row at the current tool, or at the slot's tool in the weight scan
  logic [5:0] probe_tool;
  logic probe_bit;
  assign probe_bit = mem_rdata[probe_tool];

  logic slot_we, nu_we;
  logic [5:0] slot_wa;
  logic [6:0] slot_wd;
  logic [NW-1:0] nu_wd;

  always_comb begin
    state_nxt   = state_r;
    row_cnt_nxt = row_cnt_r;
    ovf_nxt     = ovf_r;
    sw_nxt      = sw_r;
    t_nxt = t_r; j_nxt = j_r; i_nxt = i_r; s_nxt = s_r; q_nxt = q_r;
    thr_nxt = thr_r; soma_nxt = soma_r; best_nxt = best_r; bw_nxt = bw_r;
    rd_pend_nxt = 1'b0;
    mem_raddr = j_r[JW-1:0];
    probe_tool = t_r[5:0];
    slot_we = 1'b0; slot_wa = q_r[5:0]; slot_wd = t_r;
    nu_we = 1'b0; nu_wd = j_r;
    case (state_r)
      ktns_pkg::ST_LOAD: begin
        if (in_tvalid) begin
          if (row_cnt_r < NW'(ktns_pkg::MaxJobs)) row_cnt_nxt = row_cnt_r + 1'b1;
          else ovf_nxt = 1'b1;
          if (in_tuser) begin
            state_nxt = ktns_pkg::ST_NU;
            sw_nxt = '0;
            t_nxt = '0; j_nxt = '0;
          end
        end
      end
      ktns_pkg::ST_NU: begin
        // one row read at a time, each waits until it returns; scan rows for tool t
        if (t_r >= cols) begin
          state_nxt = ktns_pkg::ST_THR; j_nxt = '0; soma_nxt = '0; t_nxt = '0;
        end else if (!rd_pend_r) begin
          if (j_r >= row_cnt_r) begin
            nu_we = 1'b1; nu_wd = row_cnt_r;
            t_nxt = t_r + 1'b1; j_nxt = '0;
          end else begin
            rd_pend_nxt = 1'b1;
          end
        end else if (probe_bit) begin
          nu_we = 1'b1; nu_wd = j_r;
          t_nxt = t_r + 1'b1; j_nxt = '0;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ktns_pkg::ST_THR: begin
        // j walks k; each k sweeps the tools and counts next uses equal to k.
        // Stop at first k beyond n or with running sum above cap.
        if (t_r == '0 && !rd_pend_r && (j_r > row_cnt_r || soma_r > cap)) begin
          thr_nxt = j_r - 1'b1;
          state_nxt = ktns_pkg::ST_FILL1; t_nxt = '0; q_nxt = '0;
        end else if (t_r >= cols) begin
          j_nxt = j_r + 1'b1; t_nxt = '0;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          if (nu_rd == j_r) soma_nxt = soma_r + 1'b1;
          t_nxt = t_r + 1'b1;
        end
      end
      ktns_pkg::ST_FILL1: begin
        if (t_r >= cols) begin
          state_nxt = ktns_pkg::ST_FILL2; t_nxt = '0;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          if (nu_rd < thr_r && q_r < cap) begin
            slot_we = 1'b1; q_nxt = q_r + 1'b1;
          end
          t_nxt = t_r + 1'b1;
        end
      end
      ktns_pkg::ST_FILL2: begin
        if (t_r >= cols || q_r >= cap) begin
          state_nxt = ktns_pkg::ST_JOB; i_nxt = NW'(1); t_nxt = '0;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          if (nu_rd == thr_r) begin
            slot_we = 1'b1; q_nxt = q_r + 1'b1;
          end
          t_nxt = t_r + 1'b1;
        end
      end
      ktns_pkg::ST_JOB: begin
        // read row i, then test tool t
        mem_raddr = i_r[JW-1:0];
        if (i_r >= row_cnt_r) begin
          state_nxt = ktns_pkg::ST_DONE;
        end else if (t_r >= cols) begin
          i_nxt = i_r + 1'b1; t_nxt = '0;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else if (probe_bit) begin
          state_nxt = ktns_pkg::ST_HIT; s_nxt = '0;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      ktns_pkg::ST_HIT: begin
        // only filled slots can hold the tool
        if (s_r >= cap || s_r >= q_r) begin
          state_nxt = ktns_pkg::ST_EVW; s_nxt = '0;
          best_nxt = '0; bw_nxt = '0;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else if (slot_rd == t_r) begin
          state_nxt = ktns_pkg::ST_JOB; t_nxt = t_r + 1'b1;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ktns_pkg::ST_EVW: begin
        // start weight of slot s; an empty slot weighs n
        if (s_r >= cap) begin
          slot_we = 1'b1; slot_wa = best_r[5:0]; slot_wd = t_r;
          if (best_r >= q_r) q_nxt = q_r + 1'b1;
          if (sw_r < ktns_pkg::SwitchLimit) sw_nxt = sw_r + 1'b1;
          state_nxt = ktns_pkg::ST_JOB; t_nxt = t_r + 1'b1;
        end else if (s_r >= q_r) begin
          if (s_r == 7'd0 || bw_r < row_cnt_r) begin
            best_nxt = s_r; bw_nxt = row_cnt_r;
          end
          s_nxt = s_r + 1'b1;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          state_nxt = ktns_pkg::ST_WSCAN; j_nxt = i_r;
        end
      end
      ktns_pkg::ST_WSCAN: begin
        probe_tool = slot_rd[5:0];
        if (!rd_pend_r) begin
          if (j_r >= row_cnt_r) begin
            if (s_r == 7'd0 || bw_r < row_cnt_r) begin
              best_nxt = s_r; bw_nxt = row_cnt_r;
            end
            s_nxt = s_r + 1'b1; state_nxt = ktns_pkg::ST_EVW;
          end else begin
            rd_pend_nxt = 1'b1;
          end
        end else if (probe_bit) begin
          if (s_r == 7'd0 || bw_r < j_r) begin
            best_nxt = s_r; bw_nxt = j_r;
          end
          s_nxt = s_r + 1'b1; state_nxt = ktns_pkg::ST_EVW;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ktns_pkg::ST_DONE: begin
        if (out_tready) begin
          state_nxt = ktns_pkg::ST_LOAD; row_cnt_nxt = '0; ovf_nxt = 1'b0;
        end
      end
      default: state_nxt = ktns_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ktns_pkg::ST_LOAD;
      row_cnt_r <= '0; ovf_r <= 1'b0; sw_r <= '0; rd_pend_r <= 1'b0;
      t_r <= '0; j_r <= '0; i_r <= '0; s_r <= '0; q_r <= '0;
    end else begin
      state_r <= state_nxt;
      row_cnt_r <= row_cnt_nxt; ovf_r <= ovf_nxt; sw_r <= sw_nxt;
      rd_pend_r <= rd_pend_nxt;
      t_r <= t_nxt; j_r <= j_nxt; i_r <= i_nxt; s_r <= s_nxt; q_r <= q_nxt;
    end
  end

  // slot store: one write, registered read at the slot pointer
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[s_r[5:0]];
  end

  // next-use store: one write, registered read at the tool pointer
  always_ff @(posedge clk) begin
    if (nu_we) nu_mem[t_r[5:0]] <= nu_wd;
    nu_rd <= nu_mem[t_r[5:0]];
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt; soma_r <= soma_nxt; best_r <= best_nxt; bw_r <= bw_nxt;
  end

  assign out_tvalid = (state_r == ktns_pkg::ST_DONE);
  assign out_tdata  = {3'b000, ovf_r, row_cnt_r, sw_r};
endmodule

[hw/rtl/ktns_checker.sv]
// ----------------------------------------------------------------------------
// ktns_checker
// Port-level checks of the tool switch counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ktns_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  `CHK_ALWAYS(a_not_both, clk, rst_n, !(in_tready && out_tvalid), "ready while result waits")
  `CHK_NEXT(a_last_closes, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready, "took row after last")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `CHK_ALWAYS(a_job_total, clk, rst_n, !out_tvalid || out_tdata[19:13] != 7'd0, "zero job total")
endmodule

bind tool_switch_count_ktns ktns_checker u_ktns_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
